@@ rtl/bsc_pkg.sv @@
package bsc_pkg;

  localparam int CountBits = 48;
  localparam int PosBits   = 48;
  localparam int DataBits  = 8;
  localparam int CfgBits   = 48;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);

  typedef logic [CountBits-1:0] cnt_t;
  typedef logic [PosBits-1:0]   pos_t;
  typedef logic [DataBits-1:0]  byte_t;

  localparam cnt_t  CountMax   = '1;
  localparam pos_t  PosMax     = '1;
  localparam byte_t NewlineByte = 8'h0a;

  typedef enum logic [2:0] {
    KindDiff   = 3'd0,
    KindEofA   = 3'd1,
    KindEofB   = 3'd2,
    KindSame   = 3'd3,
    KindDiffer = 3'd4
  } kind_e;

  typedef enum logic {
    CfgReportMode = 1'b0,
    CfgByteLimit  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeFirst = 2'd0,
    ModeList  = 2'd1,
    ModeQuiet = 2'd2,
    ModeSpare = 2'd3
  } mode_e;

  typedef struct packed {
    kind_e kind;
    pos_t  position;
    pos_t  line;
    byte_t seen_a;
    byte_t seen_b;
    logic  last;
  } result_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CountMax) ? CountMax : v + cnt_t'(1);
  endfunction

  function automatic pos_t clamp_pos(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(PosMax)) ? PosMax : w[PosBits-1:0];
  endfunction

  function automatic logic reached(cnt_t v, pos_t lim);
    return 64'(v) >= 64'(lim);
  endfunction

  function automatic result_t verdict(logic differ);
    result_t r;
    r = '0;
    r.kind = differ ? KindDiffer : KindSame;
    return r;
  endfunction

endpackage

@@ rtl/bsc_in_if.sv @@
interface bsc_in_if;
  import bsc_pkg::*;

  logic  valid;
  logic  ready;
  logic  start_req;
  logic  has_a;
  logic  has_b;
  byte_t data_a;
  byte_t data_b;

  modport source (output valid, start_req, has_a, has_b, data_a, data_b, input ready);
  modport sink (input valid, start_req, has_a, has_b, data_a, data_b, output ready);
endinterface

@@ rtl/bsc_out_if.sv @@
interface bsc_out_if;
  import bsc_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] kind;
  pos_t       position;
  pos_t       line;
  byte_t      seen_a;
  byte_t      seen_b;
  logic       last;

  modport source (output valid, kind, position, line, seen_a, seen_b, last, input ready);
  modport sink (input valid, kind, position, line, seen_a, seen_b, last, output ready);
endinterface

@@ rtl/byte_stream_comparator_top.sv @@
// an item is held in the input register until the result queue holds at most
// two results; its results are then registered into the queue, and a second
// result of the same item is written with the first and leaves the queue after it
// throughput: one item per cycle while each item gives at most one result,
// bounded by the four-entry result queue, which drains one result per cycle while out_o.ready is high
// reset: async active low, clears counters, comparison state, queue pointers, config, input valid flag
module byte_stream_comparator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bsc_pkg::CfgBits-1:0] cfg_data_i,
  bsc_in_if.sink                      in_i,
  bsc_out_if.source                   out_o
);
  import bsc_pkg::*;

  mode_e mode_q;
  pos_t  limit_q;

  logic  in_vld_q;
  logic  start_q, has_a_q, has_b_q;
  byte_t da_q, db_q;

  logic  active_q, active_d;
  logic  fm_q, fm_d;
  cnt_t  cc_q, cc_d;
  cnt_t  nla_q, nla_d;
  cnt_t  nlb_q, nlb_d;

  result_t              q_mem [QDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrBits:0]    cnt_q;

  logic    proc, pop, in_acc;
  logic [1:0] n_res;
  result_t r0, r1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeFirst;
      limit_q <= PosMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgReportMode: mode_q  <= mode_e'(cfg_data_i[1:0]);
        CfgByteLimit:  limit_q <= cfg_data_i[PosBits-1:0];
        default:       limit_q <= limit_q;
      endcase
    end
  end

  // input register
  assign proc     = in_vld_q && (cnt_q <= (QPtrBits+1)'(QDepth - 2));
  assign in_i.ready = !in_vld_q || proc;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      start_q <= in_i.start_req;
      has_a_q <= in_i.has_a;
      has_b_q <= in_i.has_b;
      da_q    <= in_i.data_a;
      db_q    <= in_i.data_b;
    end
  end

  // compare logic
  always_comb begin
    logic act, fm, quiet, list_all, mism, a_end;
    cnt_t cc, nla, nlb, cc1;
    act      = start_q || active_q;
    cc       = start_q ? '0 : cc_q;
    nla      = start_q ? '0 : nla_q;
    nlb      = start_q ? '0 : nlb_q;
    fm       = start_q ? 1'b0 : fm_q;
    quiet    = mode_q[1];
    list_all = (mode_q == ModeList);
    mism     = (da_q != db_q);
    a_end    = !has_a_q;
    cc1      = sat_inc(cc);
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    active_d = act;
    fm_d     = fm;
    cc_d     = cc;
    nla_d    = nla;
    nlb_d    = nlb;
    if (act) begin
      if (reached(cc, limit_q)) begin
        r0       = verdict(fm);
        n_res    = 2'd1;
        active_d = 1'b0;
      end else if (has_a_q && has_b_q) begin
        cc_d = cc1;
        fm_d = fm || mism;
        if (da_q == NewlineByte) begin
          nla_d = sat_inc(nla);
        end
        if (db_q == NewlineByte) begin
          nlb_d = sat_inc(nlb);
        end
        if (mism && quiet) begin
          r0       = verdict(1'b1);
          n_res    = 2'd1;
          active_d = 1'b0;
        end else if (mism) begin
          r0.kind     = KindDiff;
          r0.position = clamp_pos(cc1);
          r0.line     = clamp_pos(sat_inc(nla));
          r0.seen_a   = da_q;
          r0.seen_b   = db_q;
          if (list_all) begin
            n_res = 2'd1;
            if (reached(cc1, limit_q)) begin
              r1       = verdict(1'b1);
              n_res    = 2'd2;
              active_d = 1'b0;
            end
          end else begin
            r1       = verdict(1'b1);
            n_res    = 2'd2;
            active_d = 1'b0;
          end
        end else if (reached(cc1, limit_q)) begin
          r0       = verdict(fm);
          n_res    = 2'd1;
          active_d = 1'b0;
        end
      end else if (has_a_q || has_b_q) begin
        active_d = 1'b0;
        if (quiet) begin
          r0    = verdict(1'b1);
          n_res = 2'd1;
        end else begin
          r0.kind     = a_end ? KindEofA : KindEofB;
          r0.position = clamp_pos(cc);
          r0.line     = clamp_pos(sat_inc(a_end ? nla : nlb));
          r1          = verdict(1'b1);
          n_res       = 2'd2;
        end
      end else begin
        r0       = verdict(fm);
        n_res    = 2'd1;
        active_d = 1'b0;
      end
    end
    case (n_res)
      2'd1:    r0.last = 1'b1;
      2'd2:    r1.last = 1'b1;
      default: r0.last = r0.last;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      fm_q     <= 1'b0;
      cc_q     <= '0;
      nla_q    <= '0;
      nlb_q    <= '0;
    end else if (proc) begin
      active_q <= active_d;
      fm_q     <= fm_d;
      cc_q     <= cc_d;
      nla_q    <= nla_d;
      nlb_q    <= nlb_d;
    end
  end

  // result queue
  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (proc) begin
        wr_ptr_q <= wr_ptr_q + QPtrBits'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrBits'(1);
      end
      cnt_q <= cnt_q + (QPtrBits+1)'(proc ? n_res : 2'd0)
                     - (QPtrBits+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= r0;
    end
    if (proc && n_res == 2'd2) begin
      q_mem[wr_ptr_q + QPtrBits'(1)] <= r1;
    end
  end

  assign out_o.kind     = q_mem[rd_ptr_q].kind;
  assign out_o.position = q_mem[rd_ptr_q].position;
  assign out_o.line     = q_mem[rd_ptr_q].line;
  assign out_o.seen_a   = q_mem[rd_ptr_q].seen_a;
  assign out_o.seen_b   = q_mem[rd_ptr_q].seen_b;
  assign out_o.last     = q_mem[rd_ptr_q].last;

endmodule

@@ test/byte_stream_comparator_top_tb.sv @@
`timescale 1ns / 100ps

module byte_stream_comparator_top_tb;
  import bsc_pkg::*;

  localparam int ClkHalf = 4;
  localparam int LongHold = 64;
  localparam int SettleCycles = 6;
  localparam int Phases = 14;
  localparam int PhaseItems = 92;
  localparam int HoldPhase = 6;
  localparam int MaxPrinted = 200;
  localparam longint TimeoutNs = 64'd2_000_000;

  typedef struct packed {
    logic  start_req;
    logic  has_a;
    logic  has_b;
    byte_t data_a;
    byte_t data_b;
  } pair_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_e           cfg_idx;
  logic [CfgBits-1:0] cfg_data;

  bsc_in_if  in_if ();
  bsc_out_if out_if ();

  byte_stream_comparator_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  pair_t       pair_queue[$];
  result_t     awaited[$];
  pair_t       on_bus;
  int unsigned pairs_queued;
  int unsigned pairs_taken;
  int unsigned reports_checked;
  int unsigned reg_writes;
  int unsigned errors;
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_draw;
  int unsigned hold_left;
  logic        hold_tog;
  logic        hold_seen;

  // comparator state as the predictor sees it
  mode_e mdl_mode;
  cnt_t  mdl_limit;
  logic  run_on;
  cnt_t  cmp_cnt;
  cnt_t  nl_a;
  cnt_t  nl_b;
  logic  any_diff;

  function automatic cnt_t count_up(cnt_t v);
    return (v == CountMax) ? v : v + cnt_t'(1);
  endfunction

  function automatic void push_report(kind_e k, cnt_t pos, cnt_t ln, byte_t a, byte_t b);
    result_t r;
    r = '0;
    r.kind = k;
    r.position = pos;
    r.line = ln;
    r.seen_a = a;
    r.seen_b = b;
    awaited.insert(awaited.size(), r);
  endfunction

  function automatic void close_run(logic differ);
    push_report(differ ? KindDiffer : KindSame, '0, '0, '0, '0);
    run_on = 1'b0;
  endfunction

  task automatic model_pair(input pair_t p);
    logic quiet;
    int   base;
    quiet = mdl_mode[1];
    base = awaited.size();
    if (p.start_req) begin
      run_on = 1'b1;
      cmp_cnt = '0;
      nl_a = '0;
      nl_b = '0;
      any_diff = 1'b0;
    end
    if (run_on) begin
      if (cmp_cnt >= mdl_limit) begin
        close_run(any_diff);
      end else if (p.has_a && p.has_b) begin
        cmp_cnt = count_up(cmp_cnt);
        if (p.data_a != p.data_b) begin
          any_diff = 1'b1;
          if (!quiet) push_report(KindDiff, cmp_cnt, count_up(nl_a), p.data_a, p.data_b);
          if (mdl_mode != ModeList) close_run(1'b1);
        end
        if (p.data_a == NewlineByte) nl_a = count_up(nl_a);
        if (p.data_b == NewlineByte) nl_b = count_up(nl_b);
        if (run_on && cmp_cnt >= mdl_limit) close_run(any_diff);
      end else if (p.has_a || p.has_b) begin
        if (!quiet) begin
          push_report(p.has_a ? KindEofB : KindEofA, cmp_cnt,
                      count_up(p.has_a ? nl_b : nl_a), '0, '0);
        end
        close_run(1'b1);
      end else begin
        close_run(any_diff);
      end
      if (awaited.size() > base) awaited[awaited.size() - 1].last = 1'b1;
    end
  endtask

  function automatic void note_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (errors < MaxPrinted) $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_report();
    result_t want;
    if (awaited.size() == 0) begin
      if (errors < MaxPrinted) begin
        $display("%0t: unexpected result kind %0h position %0h line %0h", $time,
                 out_if.kind, out_if.position, out_if.line);
      end
      errors++;
    end else begin
      want = awaited.pop_front();
      reports_checked++;
      note_field("kind", want.kind, out_if.kind);
      note_field("position", want.position, out_if.position);
      note_field("line", want.line, out_if.line);
      note_field("seen_a", want.seen_a, out_if.seen_a);
      note_field("seen_b", want.seen_b, out_if.seen_b);
      note_field("last", want.last, out_if.last);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgBits-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgReportMode) mdl_mode = mode_e'(val[1:0]);
    else mdl_limit = val;
    reg_writes++;
  endtask

  // wait until every item is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (pairs_taken != pairs_queued || awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_pair(input logic s, input logic ha, input logic hb,
                            input byte_t a, input byte_t b);
    pair_t p;
    p.start_req = s;
    p.has_a = ha;
    p.has_b = hb;
    p.data_a = a;
    p.data_b = b;
    pair_queue.insert(pair_queue.size(), p);
    pairs_queued++;
  endtask

  task automatic queue_comparison(input int len, input int diff_pct);
    int    i;
    int    ending;
    byte_t a;
    byte_t b;
    ending = $urandom_range(0, 3);
    for (i = 0; i < len; i++) begin
      a = ($urandom_range(0, 7) == 0) ? NewlineByte : byte_t'($urandom);
      b = a;
      if ($urandom_range(0, 99) < diff_pct) begin
        b = ($urandom_range(0, 3) == 0) ? NewlineByte : byte_t'($urandom);
      end
      queue_pair(i == 0, 1'b1, 1'b1, a, b);
    end
    // both end, A ends, B ends, or leave the comparison open
    if (ending != 3) begin
      queue_pair(1'b0, ending == 2, ending == 1, byte_t'($urandom), byte_t'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.start_req <= 1'b0;
      in_if.has_a <= 1'b0;
      in_if.has_b <= 1'b0;
      in_if.data_a <= '0;
      in_if.data_b <= '0;
      tx_wait <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        model_pair(on_bus);
        pairs_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_wait != 0) begin
          in_if.valid <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (pair_queue.size() != 0) begin
          on_bus = pair_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.start_req <= on_bus.start_req;
          in_if.has_a <= on_bus.has_a;
          in_if.has_b <= on_bus.has_b;
          in_if.data_a <= on_bus.data_a;
          in_if.data_b <= on_bus.data_b;
          tx_wait <= $urandom_range(0, tx_gap_max);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_report();
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        hold_left <= LongHold;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= (hold_left == 1);
      end else if (out_if.valid && out_if.ready) begin
        rx_draw = $urandom_range(0, rx_gap_max);
        rx_wait <= rx_draw;
        out_if.ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_if.ready <= (rx_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          ph;
    int          diff_pct;
    int unsigned target;
    logic [63:0] r64;
    mode_e       m;
    cnt_t        lim;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgReportMode;
    cfg_data = '0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_tog = 1'b0;
    pairs_queued = 0;
    pairs_taken = 0;
    reports_checked = 0;
    reg_writes = 0;
    errors = 0;
    mdl_mode = ModeFirst;
    mdl_limit = PosMax;
    run_on = 1'b0;
    cmp_cnt = '0;
    nl_a = '0;
    nl_b = '0;
    any_diff = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CfgReportMode, CfgBits'(ModeFirst));
    write_reg(CfgByteLimit, PosMax);
    // idle item, then a run that stops at its first difference
    queue_pair(1'b0, 1'b1, 1'b1, 8'h00, 8'hff);
    queue_pair(1'b1, 1'b1, 1'b1, 8'h00, 8'h00);
    queue_pair(1'b0, 1'b1, 1'b1, NewlineByte, NewlineByte);
    queue_pair(1'b0, 1'b1, 1'b1, 8'hff, 8'hff);
    queue_pair(1'b0, 1'b1, 1'b1, 8'hff, 8'h00);
    queue_pair(1'b0, 1'b1, 1'b1, 8'h01, 8'h02);
    // both empty, B empty, newline mismatch, A ends after one line
    queue_pair(1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
    queue_pair(1'b1, 1'b1, 1'b0, 8'h41, 8'h00);
    queue_pair(1'b1, 1'b1, 1'b1, NewlineByte, 8'h20);
    queue_pair(1'b1, 1'b1, 1'b1, NewlineByte, NewlineByte);
    queue_pair(1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
    settle();
    write_reg(CfgReportMode, CfgBits'(ModeList));
    queue_pair(1'b1, 1'b1, 1'b1, 8'h10, 8'h11);
    queue_pair(1'b0, 1'b1, 1'b1, NewlineByte, 8'h0b);
    queue_pair(1'b0, 1'b1, 1'b1, 8'h33, 8'h33);
    queue_pair(1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
    settle();
    write_reg(CfgReportMode, CfgBits'(ModeQuiet));
    queue_pair(1'b1, 1'b1, 1'b1, 8'h05, 8'h06);
    queue_pair(1'b1, 1'b0, 1'b1, 8'h00, 8'h00);
    settle();
    write_reg(CfgReportMode, CfgBits'(ModeSpare));
    queue_pair(1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_pair(1'b1, 1'b1, 1'b1, 8'h07, 8'h07);
    queue_pair(1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
    settle();
    // zero limit ignores the data, then a limit reached on a byte
    write_reg(CfgReportMode, CfgBits'(ModeFirst));
    write_reg(CfgByteLimit, '0);
    queue_pair(1'b1, 1'b1, 1'b1, 8'h09, 8'h08);
    settle();
    write_reg(CfgByteLimit, CfgBits'(2));
    queue_pair(1'b1, 1'b1, 1'b1, 8'h01, 8'h01);
    queue_pair(1'b0, 1'b1, 1'b1, 8'h02, 8'h02);
    settle();
    // limit lowered while a comparison is open
    write_reg(CfgReportMode, CfgBits'(ModeList));
    write_reg(CfgByteLimit, PosMax);
    queue_pair(1'b1, 1'b1, 1'b1, 8'h03, 8'h04);
    queue_pair(1'b0, 1'b1, 1'b1, 8'h05, 8'h05);
    settle();
    write_reg(CfgByteLimit, CfgBits'(1));
    queue_pair(1'b0, 1'b1, 1'b1, 8'h00, 8'h00);

    for (ph = 0; ph < Phases; ph++) begin
      settle();
      r64 = {$urandom, $urandom};
      m = (ph < 4) ? mode_e'(ph) : mode_e'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: lim = PosMax;
        1: lim = cnt_t'($urandom_range(1, 40));
        2: lim = r64[63:16];
        default: lim = cnt_t'($urandom_range(41, 400));
      endcase
      if (ph == 0) lim = PosMax;
      if (ph == 1) lim = '0;
      if (ph == HoldPhase) begin
        m = ModeList;
        lim = PosMax;
      end
      write_reg(CfgReportMode, {r64[47:2], m});
      write_reg(CfgByteLimit, lim);
      tx_gap_max <= (ph % 3 == 0 || ph == HoldPhase) ? 0 : 7;
      rx_gap_max <= (ph % 4 == 2) ? 0 : 7;
      if (ph == HoldPhase) diff_pct = 60;
      else if (m == ModeFirst) diff_pct = $urandom_range(1, 8);
      else diff_pct = $urandom_range(0, 50);
      target = pairs_queued + PhaseItems;
      while (pairs_queued < target) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_pair($urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom),
                     byte_t'($urandom), byte_t'($urandom));
        end else if ($urandom_range(0, 19) == 0) begin
          queue_comparison($urandom_range(25, 60), diff_pct);
        end else begin
          queue_comparison($urandom_range(1, 24), diff_pct);
        end
      end
      if (ph == HoldPhase) begin
        repeat (8) @(posedge clk);
        hold_tog <= ~hold_tog;
      end
    end
    settle();

    $display("ran %0d items through the comparator, checked %0d results", pairs_taken,
             reports_checked);
    $display("all four report modes, zero to full byte limits, %0d register writes",
             reg_writes);
    if (errors == 0) begin
      $display("byte_stream_comparator_top test passed");
    end else begin
      $display("byte_stream_comparator_top test failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("%0t: timeout, %0d results still expected", $time, awaited.size());
    $display("byte_stream_comparator_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bsc_pkg.sv
rtl/bsc_in_if.sv
rtl/bsc_out_if.sv
rtl/byte_stream_comparator_top.sv
test/byte_stream_comparator_top_tb.sv
